// ===== rtl/rwlq_pkg.sv =====
package rwlq_pkg;

   localparam int READ_QUEUE_DEPTH_DEF  = 16;
   localparam int WRITE_QUEUE_DEPTH_DEF = 16;
   localparam int REQUESTER_ID_BITS_DEF = 8;
   localparam int MAX_READERS_DEF       = 255;

   localparam int ID_PORT_W   = 8;
   localparam int MAX_WAKE    = 16;
   localparam int WAKE_CNT_W  = $clog2(MAX_WAKE + 1);

   typedef enum logic [1:0] {
      CMD_READ_LOCK    = 2'd0,
      CMD_WRITE_LOCK   = 2'd1,
      CMD_READ_UNLOCK  = 2'd2,
      CMD_WRITE_UNLOCK = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_GRANTED   = 3'd0,
      STS_QUEUED    = 3'd1,
      STS_WOKEN     = 3'd2,
      STS_RELEASED  = 3'd3,
      STS_QFULL     = 3'd4,
      STS_RCFULL    = 3'd5,
      STS_BADUNLOCK = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAKE
   } state_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic single;
   } fifo_stat_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

endpackage

// ===== rtl/reader_writer_lock_queue.sv =====
// A command is accepted with start while idle; its result beat is shown in the next
// cycle. A write unlock that wakes k readers (k <= 16) reports them instead from
// the wake state, one woken reader per cycle from the reader queue memory port.
// Reset: synchronous; lock free, no readers, both wait queues empty.
// The receiver cannot stall: each rsp_valid beat is taken in the cycle it is shown.
module reader_writer_lock_queue
   import rwlq_pkg::*;
#(
   parameter int READ_QUEUE_DEPTH  = READ_QUEUE_DEPTH_DEF,
   parameter int WRITE_QUEUE_DEPTH = WRITE_QUEUE_DEPTH_DEF,
   parameter int REQUESTER_ID_BITS = REQUESTER_ID_BITS_DEF,
   parameter int MAX_READERS       = MAX_READERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_command,
   input  logic [ID_PORT_W-1:0] req_requester_id,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic [ID_PORT_W-1:0] rsp_target_id,
   output logic                 rsp_grant_is_write,
   output logic                 rsp_last
);

   localparam int ID_W = (REQUESTER_ID_BITS < ID_PORT_W) ? REQUESTER_ID_BITS : ID_PORT_W;

   fifo_stat_type   rq_stat, wq_stat;
   fifo_ctl_type    rq_ctl, wq_ctl;
   logic [ID_W-1:0] rq_head, wq_head;
   logic [ID_W-1:0] push_id;

   rwlq_ctrl #(
      .MAX_READERS (MAX_READERS),
      .ID_W        (ID_W)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_requester_id   (req_requester_id),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_target_id      (rsp_target_id),
      .rsp_grant_is_write (rsp_grant_is_write),
      .rsp_last           (rsp_last),
      .rq_stat            (rq_stat),
      .wq_stat            (wq_stat),
      .rq_head            (rq_head),
      .wq_head            (wq_head),
      .rq_ctl             (rq_ctl),
      .wq_ctl             (wq_ctl),
      .push_id            (push_id)
   );

   rwlq_queue #(
      .DEPTH  (READ_QUEUE_DEPTH),
      .DATA_W (ID_W)
   ) u_read_q (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rq_ctl),
      .push_data (push_id),
      .head_data (rq_head),
      .stat      (rq_stat)
   );

   rwlq_queue #(
      .DEPTH  (WRITE_QUEUE_DEPTH),
      .DATA_W (ID_W)
   ) u_write_q (
      .clock     (clock),
      .reset     (reset),
      .ctl       (wq_ctl),
      .push_data (push_id),
      .head_data (wq_head),
      .stat      (wq_stat)
   );

endmodule

// ===== rtl/rwlq_queue.sv =====
module rwlq_queue
   import rwlq_pkg::*;
#(
   parameter int DEPTH  = READ_QUEUE_DEPTH_DEF,
   parameter int DATA_W = REQUESTER_ID_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  fifo_ctl_type      ctl,
   input  logic [DATA_W-1:0] push_data,
   output logic [DATA_W-1:0] head_data,
   output fifo_stat_type     stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  tail_sum;
   logic [PTR_W-1:0]  tail;
   logic [DATA_W-1:0] rd_data_ff;

   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(tail_sum);

   always_comb begin
      head_in = head_ff;
      if (ctl.pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      count_in = count_ff;
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // read the next head every cycle; a push to an empty queue goes via mem to rd_data_ff
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail] <= push_data;
      end
      rd_data_ff <= mem[head_in];
   end

   assign head_data   = rd_data_ff;
   assign stat.empty  = (count_ff == '0);
   assign stat.full   = (count_ff == CNT_W'(DEPTH));
   assign stat.single = (count_ff == CNT_W'(1));

endmodule

// ===== rtl/rwlq_ctrl.sv =====
module rwlq_ctrl
   import rwlq_pkg::*;
#(
   parameter int MAX_READERS = MAX_READERS_DEF,
   parameter int ID_W        = REQUESTER_ID_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_command,
   input  logic [ID_PORT_W-1:0] req_requester_id,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic [ID_PORT_W-1:0] rsp_target_id,
   output logic                 rsp_grant_is_write,
   output logic                 rsp_last,
   input  fifo_stat_type        rq_stat,
   input  fifo_stat_type        wq_stat,
   input  logic [ID_W-1:0]      rq_head,
   input  logic [ID_W-1:0]      wq_head,
   output fifo_ctl_type         rq_ctl,
   output fifo_ctl_type         wq_ctl,
   output logic [ID_W-1:0]      push_id
);

   localparam int RC_W = $clog2(MAX_READERS + 1);

   state_type             state_ff, state_in;
   cmd_type               cmd_ff;
   logic [ID_W-1:0]       id_ff;
   logic                  writer_held_ff, writer_held_in;
   logic [RC_W-1:0]       reader_count_ff, reader_count_in;
   logic [WAKE_CNT_W-1:0] wake_cnt_ff, wake_cnt_in;
   logic                  accept;
   logic                  rc_room;
   logic                  wake_start;
   logic                  wake_more;
   status_type            status;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign rc_room = (reader_count_ff < RC_W'(MAX_READERS));
   assign push_id = id_ff;

   assign wake_start = (cmd_ff == CMD_WRITE_UNLOCK) && writer_held_ff && wq_stat.empty
                       && !rq_stat.empty && rc_room;
   // keep waking while readers remain and both the per-command and holder limits allow
   assign wake_more  = !rq_stat.single && (wake_cnt_ff < WAKE_CNT_W'(MAX_WAKE - 1))
                       && (reader_count_ff < RC_W'(MAX_READERS - 1));

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_command);
         id_ff  <= ID_W'(req_requester_id);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = wake_start ? ST_WAKE : ST_IDLE;
         end
         ST_WAKE: begin
            state_in = wake_more ? ST_WAKE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      writer_held_in     = writer_held_ff;
      reader_count_in    = reader_count_ff;
      wake_cnt_in        = wake_cnt_ff;
      rq_ctl             = '0;
      wq_ctl             = '0;
      rsp_valid          = 1'b0;
      status             = STS_RELEASED;
      rsp_target_id      = ID_PORT_W'(id_ff);
      rsp_grant_is_write = 1'b0;
      rsp_last           = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            wake_cnt_in = '0;
         end
         ST_EXEC: begin
            rsp_valid = 1'b1;
            unique case (cmd_ff)
               CMD_READ_LOCK: begin
                  if (!writer_held_ff) begin
                     if (!rc_room) begin
                        status = STS_RCFULL;
                     end else begin
                        reader_count_in = reader_count_ff + RC_W'(1);
                        status          = STS_GRANTED;
                     end
                  end else if (rq_stat.full) begin
                     status = STS_QFULL;
                  end else begin
                     rq_ctl.push = 1'b1;
                     status      = STS_QUEUED;
                  end
               end
               CMD_WRITE_LOCK: begin
                  rsp_grant_is_write = 1'b1;
                  if (!writer_held_ff && reader_count_ff == '0) begin
                     writer_held_in = 1'b1;
                     status         = STS_GRANTED;
                  end else if (wq_stat.full) begin
                     status = STS_QFULL;
                  end else begin
                     wq_ctl.push = 1'b1;
                     status      = STS_QUEUED;
                  end
               end
               CMD_READ_UNLOCK: begin
                  if (reader_count_ff == '0) begin
                     status = STS_BADUNLOCK;
                  end else begin
                     reader_count_in = reader_count_ff - RC_W'(1);
                     if (reader_count_ff == RC_W'(1) && !wq_stat.empty) begin
                        // last reader out: hand the lock to the head writer
                        writer_held_in     = 1'b1;
                        wq_ctl.pop         = 1'b1;
                        status             = STS_WOKEN;
                        rsp_target_id      = ID_PORT_W'(wq_head);
                        rsp_grant_is_write = 1'b1;
                     end else begin
                        status = STS_RELEASED;
                     end
                  end
               end
               CMD_WRITE_UNLOCK: begin
                  rsp_grant_is_write = 1'b1;
                  if (!writer_held_ff) begin
                     status = STS_BADUNLOCK;
                  end else if (!wq_stat.empty) begin
                     wq_ctl.pop    = 1'b1;
                     status        = STS_WOKEN;
                     rsp_target_id = ID_PORT_W'(wq_head);
                  end else begin
                     writer_held_in = 1'b0;
                     // readers are reported beat by beat from the wake state
                     if (wake_start) rsp_valid = 1'b0;
                     status = STS_RELEASED;
                  end
               end
               default: status = STS_BADUNLOCK;
            endcase
         end
         ST_WAKE: begin
            rsp_valid       = 1'b1;
            rq_ctl.pop      = 1'b1;
            reader_count_in = reader_count_ff + RC_W'(1);
            wake_cnt_in     = wake_cnt_ff + WAKE_CNT_W'(1);
            status          = STS_WOKEN;
            rsp_target_id   = ID_PORT_W'(rq_head);
            rsp_last        = !wake_more;
         end
         default: begin
            wake_cnt_in = '0;
         end
      endcase
   end

   assign rsp_status = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         writer_held_ff  <= 1'b0;
         reader_count_ff <= '0;
         wake_cnt_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         writer_held_ff  <= writer_held_in;
         reader_count_ff <= reader_count_in;
         wake_cnt_ff     <= wake_cnt_in;
      end
   end

`ifndef SYNTH
   a_excl_hold: assert property (@(posedge clock) disable iff (reset)
      !(writer_held_ff && reader_count_ff != '0))
      else $error("writer and readers hold the lock together");

   a_wake_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAKE) |-> !rq_stat.empty)
      else $error("reader wake with empty queue");

   a_wake_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAKE) |-> (wake_cnt_ff < WAKE_CNT_W'(MAX_WAKE)))
      else $error("too many readers woken by one command");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> (state_ff == ST_IDLE))
      else $error("beat after last beat of a command");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !((rq_ctl.push || rq_ctl.pop) && (wq_ctl.push || wq_ctl.pop)))
      else $error("both queues touched by one command step");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import rwlq_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_ITEMS = 70;
   localparam int CALM_ITEMS   = 20;

   typedef struct {
      status_type     status;
      logic [7:0]     target;
      logic           is_write;
      logic           last;
   } outcome_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_command;
   logic [ID_PORT_W-1:0] req_requester_id;
   logic                 rsp_valid;
   logic [2:0]           rsp_status;
   logic [ID_PORT_W-1:0] rsp_target_id;
   logic                 rsp_grant_is_write;
   logic                 rsp_last;

   // lock model state
   logic        lock_writer_held;
   int          lock_reader_cnt;
   logic [7:0]  reader_waitq[$];
   logic [7:0]  writer_waitq[$];
   outcome_type pending_outcomes[$];

   int err_cnt;
   int cycle_cnt;

   reader_writer_lock_queue i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_requester_id   (req_requester_id),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_target_id      (rsp_target_id),
      .rsp_grant_is_write (rsp_grant_is_write),
      .rsp_last           (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      err_cnt++;
   endtask

   function automatic outcome_type make_outcome(status_type s, logic [7:0] t, logic w);
      outcome_type o;
      o.status   = s;
      o.target   = t;
      o.is_write = w;
      o.last     = 1'b0;
      return o;
   endfunction

   task automatic predict_lock_outcome(cmd_type cmd, logic [7:0] id);
      outcome_type res[$];
      case (cmd)
         CMD_READ_LOCK: begin
            if (!lock_writer_held) begin
               if (lock_reader_cnt >= MAX_READERS_DEF) begin
                  res.push_back(make_outcome(STS_RCFULL, id, 1'b0));
               end else begin
                  lock_reader_cnt++;
                  res.push_back(make_outcome(STS_GRANTED, id, 1'b0));
               end
            end else if (reader_waitq.size() >= READ_QUEUE_DEPTH_DEF) begin
               res.push_back(make_outcome(STS_QFULL, id, 1'b0));
            end else begin
               reader_waitq.push_back(id);
               res.push_back(make_outcome(STS_QUEUED, id, 1'b0));
            end
         end
         CMD_WRITE_LOCK: begin
            if (!lock_writer_held && lock_reader_cnt == 0) begin
               lock_writer_held = 1'b1;
               res.push_back(make_outcome(STS_GRANTED, id, 1'b1));
            end else if (writer_waitq.size() >= WRITE_QUEUE_DEPTH_DEF) begin
               res.push_back(make_outcome(STS_QFULL, id, 1'b1));
            end else begin
               writer_waitq.push_back(id);
               res.push_back(make_outcome(STS_QUEUED, id, 1'b1));
            end
         end
         CMD_READ_UNLOCK: begin
            if (lock_reader_cnt == 0) begin
               res.push_back(make_outcome(STS_BADUNLOCK, id, 1'b0));
            end else begin
               lock_reader_cnt--;
               if (lock_reader_cnt == 0 && writer_waitq.size() > 0) begin
                  lock_writer_held = 1'b1;
                  res.push_back(make_outcome(STS_WOKEN, writer_waitq.pop_front(), 1'b1));
               end else begin
                  res.push_back(make_outcome(STS_RELEASED, id, 1'b0));
               end
            end
         end
         default: begin
            if (!lock_writer_held) begin
               res.push_back(make_outcome(STS_BADUNLOCK, id, 1'b1));
            end else if (writer_waitq.size() > 0) begin
               res.push_back(make_outcome(STS_WOKEN, writer_waitq.pop_front(), 1'b1));
            end else begin
               lock_writer_held = 1'b0;
               // wake queued readers in order, bounded per command and by holder limit
               while (reader_waitq.size() > 0 && res.size() < MAX_WAKE &&
                      lock_reader_cnt < MAX_READERS_DEF) begin
                  lock_reader_cnt++;
                  res.push_back(make_outcome(STS_WOKEN, reader_waitq.pop_front(), 1'b0));
               end
               if (res.size() == 0)
                  res.push_back(make_outcome(STS_RELEASED, id, 1'b1));
            end
         end
      endcase
      res[res.size()-1].last = 1'b1;
      foreach (res[i])
         pending_outcomes.push_back(res[i]);
   endtask

   // Raise start and hold it until the beat is taken; leave it high for a back-to-back beat.
   task automatic send_command(cmd_type cmd, logic [7:0] id);
      start            <= 1'b1;
      req_command      <= cmd;
      req_requester_id <= id;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      predict_lock_outcome(cmd, id);
   endtask

   task automatic idle_burst(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if ($urandom_range(3) == 0)
         idle_burst($urandom_range(1, 12));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_results
      outcome_type exp_o;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected beat status=%0d id=%0h",
                                      rsp_status, rsp_target_id));
         end else begin
            exp_o = pending_outcomes.pop_front();
            if (rsp_status !== exp_o.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_status, exp_o.status));
            if (rsp_target_id !== exp_o.target)
               report_mismatch($sformatf("target_id got %0h want %0h",
                                         rsp_target_id, exp_o.target));
            if (rsp_grant_is_write !== exp_o.is_write)
               report_mismatch($sformatf("grant_is_write got %0b want %0b",
                                         rsp_grant_is_write, exp_o.is_write));
            if (rsp_last !== exp_o.last)
               report_mismatch($sformatf("last got %0b want %0b",
                                         rsp_last, exp_o.last));
         end
      end
   end

   // bad unlocks, grants, queueing, every wake path and both release kinds
   task automatic test_basic_commands();
      send_command(CMD_READ_UNLOCK,  8'h00);
      send_command(CMD_WRITE_UNLOCK, 8'hFF);
      send_command(CMD_READ_LOCK,    8'h00);
      maybe_idle();
      send_command(CMD_READ_LOCK,    8'hFF);
      send_command(CMD_WRITE_LOCK,   8'h11);
      send_command(CMD_READ_UNLOCK,  8'h00);
      maybe_idle();
      send_command(CMD_READ_UNLOCK,  8'hFF);
      send_command(CMD_READ_LOCK,    8'h22);
      send_command(CMD_READ_LOCK,    8'h33);
      send_command(CMD_WRITE_LOCK,   8'h44);
      maybe_idle();
      send_command(CMD_WRITE_UNLOCK, 8'h11);
      send_command(CMD_WRITE_UNLOCK, 8'h44);
      send_command(CMD_WRITE_LOCK,   8'h55);
      maybe_idle();
      send_command(CMD_READ_UNLOCK,  8'h22);
      send_command(CMD_READ_UNLOCK,  8'h33);
      send_command(CMD_WRITE_UNLOCK, 8'h55);
      send_command(CMD_WRITE_LOCK,   8'hAA);
      maybe_idle();
      send_command(CMD_WRITE_UNLOCK, 8'hAA);
      send_command(CMD_READ_UNLOCK,  8'h5A);
   endtask

   // fill both wait queues past depth, then drain them, ending with a full reader wake
   task automatic test_queue_full();
      send_command(CMD_WRITE_LOCK, 8'h01);
      for (int i = 0; i <= READ_QUEUE_DEPTH_DEF; i++) begin
         send_command(CMD_READ_LOCK, 8'($urandom_range(255)));
         maybe_idle();
      end
      for (int i = 0; i <= WRITE_QUEUE_DEPTH_DEF; i++) begin
         send_command(CMD_WRITE_LOCK, 8'($urandom_range(255)));
         maybe_idle();
      end
      for (int i = 0; i <= WRITE_QUEUE_DEPTH_DEF; i++) begin
         send_command(CMD_WRITE_UNLOCK, 8'($urandom_range(255)));
         maybe_idle();
      end
      for (int i = 0; i < READ_QUEUE_DEPTH_DEF; i++) begin
         send_command(CMD_READ_UNLOCK, 8'($urandom_range(255)));
         maybe_idle();
      end
   endtask

   // free the lock of writers, push the reader count to its ceiling and one past it, then queue a writer
   task automatic test_reader_limit();
      int n;
      n = 0;
      while (lock_writer_held)
         send_command(CMD_WRITE_UNLOCK, 8'h7E);
      while (lock_reader_cnt < MAX_READERS_DEF) begin
         send_command(CMD_READ_LOCK, 8'(n));
         n++;
      end
      send_command(CMD_READ_LOCK, 8'hEE);
      send_command(CMD_WRITE_LOCK, 8'h77);
   endtask

   // mostly legal lock traffic steered by the model state, with some noise
   task automatic test_random_traffic();
      int      r;
      cmd_type cmd;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         r = $urandom_range(99);
         if (r < 6)
            cmd = cmd_type'($urandom_range(3));
         else if (r < 40)
            cmd = CMD_READ_LOCK;
         else if (r < 60)
            cmd = CMD_WRITE_LOCK;
         else if (r < 82)
            cmd = (lock_reader_cnt > 0) ? CMD_READ_UNLOCK : CMD_READ_LOCK;
         else
            cmd = lock_writer_held ? CMD_WRITE_UNLOCK : CMD_WRITE_LOCK;
         send_command(cmd, 8'($urandom_range(255)));
         if (k < RANDOM_ITEMS - CALM_ITEMS)
            maybe_idle();
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_command      = CMD_READ_LOCK;
      req_requester_id = '0;
      lock_writer_held = 1'b0;
      lock_reader_cnt  = 0;
      err_cnt          = 0;
      cycle_cnt        = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_basic_commands();
      wait_drained();
      test_queue_full();
      wait_drained();
      test_random_traffic();
      wait_drained();
      test_reader_limit();
      wait_drained();

      if (pending_outcomes.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
      if (err_cnt == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
